>>> design/fasc_pkg.sv
// Shared types, constants and codes of the fixed address segment carver.
package fasc_pkg;

	localparam int MAX_RANGES = 16;
	localparam int IDX_W      = $clog2(MAX_RANGES);
	localparam int CNT_W      = $clog2(MAX_RANGES + 1);
	localparam int MEM_WORDS  = 4096;
	localparam int ADDR_W     = 12;
	localparam int LEN_W      = 13;
	localparam int SPAN_W     = 14;

	typedef enum logic [1:0] {
		STATUS_OK   = 2'd0,
		STATUS_MISS = 2'd1,
		STATUS_FULL = 2'd2
	} status_t;

	typedef enum logic {
		CMD_INIT  = 1'b0,
		CMD_ALLOC = 1'b1
	} cmd_t;

	typedef struct packed {
		logic [ADDR_W-1:0] base;
		logic [LEN_W-1:0]  length;
	} entry_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		entry_t           wdata;
		logic [IDX_W-1:0] raddr;
	} mem_req_t;

	typedef enum logic [3:0] {
		ST_RESET,
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_DN_RD,
		ST_DN_WR,
		ST_UP_RD,
		ST_UP_WR,
		ST_SPLIT_LO,
		ST_SPLIT_HI,
		ST_DONE
	} fsm_state_t;

endpackage

>>> design/fasc_if.sv
// Request and response channel interfaces of the fixed address segment carver.
interface fasc_req_if import fasc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              cmd;
	logic [ADDR_W-1:0] seg_start;
	logic [LEN_W-1:0]  seg_size;

	modport source(output valid, cmd, seg_start, seg_size, input ready);
	modport sink(input valid, cmd, seg_start, seg_size, output ready);
endinterface

interface fasc_rsp_if import fasc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [1:0]       status;
	logic [CNT_W-1:0] free_count;

	modport source(output valid, status, free_count, input ready);
	modport sink(input valid, status, free_count, output ready);
endinterface

>>> design/fixed_address_segment_carver.sv
// Top level of the fixed address segment carver.
// The block keeps an address-ordered table of up to 16 free ranges in a single-port-read,
// single-port-write memory and answers each request word with one response word. An init word
// writes the initial range and goes straight to the done state. An allocate word reads, then
// compares, one table entry after another; a miss reads once more to notice the end of the
// table. A removed or split range shifts each entry moved by a read and a write, plus one final
// read. A split then writes both halves. Every word enters in the idle state and leaves in the
// done state. The registered table read port is why each entry needs a read and a compare.
// A result that waits in the output register holds the next item in its done state until the
// response word is taken. A new request word is taken as soon as the previous result sits in
// the output register. Right after reset the block writes the initial range in its reset state
// before it takes a request.
module fixed_address_segment_carver import fasc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	fasc_req_if.sink         req,
	fasc_rsp_if.source       rsp,
	input  logic             cfg_we,
	input  logic [LEN_W-1:0] cfg_wdata
);

	mem_req_t mem_req;
	entry_t   mem_rdata;

	fasc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata)
	);

	fasc_table_ram u_ram (
		.clk       (clk),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata)
	);

endmodule

>>> design/fasc_table_ram.sv
// Free range table memory: one write port and one registered read port.
module fasc_table_ram import fasc_pkg::*; (
	input  logic     clk,
	input  mem_req_t mem_req,
	output entry_t   mem_rdata
);

	entry_t mem [MAX_RANGES];

	always_ff @(posedge clk) begin
		if (mem_req.we) begin
			mem[mem_req.waddr] <= mem_req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		mem_rdata <= mem[mem_req.raddr];
	end

endmodule

>>> design/fasc_ctrl.sv
// Sequencer that scans, carves and shifts the free range table.
module fasc_ctrl import fasc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	fasc_req_if.sink         req,
	fasc_rsp_if.source       rsp,
	input  logic             cfg_we,
	input  logic [LEN_W-1:0] cfg_wdata,
	output mem_req_t         mem_req,
	input  entry_t           mem_rdata
);

	fsm_state_t        state_q, state_d;
	logic [LEN_W-1:0]  total_size_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  idx_q;
	logic [CNT_W-1:0]  k_q;
	logic [ADDR_W-1:0] start_q;
	logic [ADDR_W-1:0] base_q;
	logic [LEN_W-1:0]  size_q;
	logic [SPAN_W-1:0] stop_q;
	logic [SPAN_W-1:0] end_q;
	status_t           status_q;
	logic              rsp_valid_q;
	status_t           rsp_status_q;
	logic [CNT_W-1:0]  rsp_count_q;

	logic [LEN_W-1:0]  build_len;
	logic [CNT_W-1:0]  build_cnt;
	logic [SPAN_W-1:0] rd_end;
	logic              hit, at_front, at_tail, size_zero, full;
	logic              accept, rsp_load;
	logic [CNT_W-1:0]  k_next, k_prev, idx_next;
	logic              dn_more, up_more;

	always_comb begin
		build_len = (total_size_q > LEN_W'(MEM_WORDS)) ? LEN_W'(MEM_WORDS) : total_size_q;
		build_cnt = (build_len == '0) ? '0 : CNT_W'(1);
		rd_end    = SPAN_W'(mem_rdata.base) + SPAN_W'(mem_rdata.length);
		hit       = (mem_rdata.base <= start_q) && (rd_end >= stop_q);
		at_front  = (mem_rdata.base == start_q);
		at_tail   = (rd_end == stop_q);
		size_zero = (size_q == '0);
		full      = (count_q >= CNT_W'(MAX_RANGES));
		accept    = req.valid && req.ready;
		rsp_load  = (state_q == ST_DONE) && (!rsp_valid_q || rsp.ready);
		k_next    = k_q + CNT_W'(1);
		k_prev    = k_q - CNT_W'(1);
		idx_next  = idx_q + CNT_W'(1);
		dn_more   = (k_next < count_q);
		up_more   = (k_q > idx_next);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_RESET: begin
				state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (req.valid) begin
					state_d = (req.cmd == CMD_INIT) ? ST_DONE : ST_SCAN_RD;
				end
			end
			ST_SCAN_RD: begin
				state_d = (idx_q >= count_q) ? ST_DONE : ST_SCAN_CMP;
			end
			ST_SCAN_CMP: begin
				if (!hit) begin
					state_d = ST_SCAN_RD;
				end else if (size_zero) begin
					state_d = ST_DONE;
				end else if (at_front && at_tail) begin
					state_d = ST_DN_RD;
				end else if (at_front || at_tail || full) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_UP_RD;
				end
			end
			ST_DN_RD: begin
				state_d = dn_more ? ST_DN_WR : ST_DONE;
			end
			ST_DN_WR: begin
				state_d = ST_DN_RD;
			end
			ST_UP_RD: begin
				state_d = up_more ? ST_UP_WR : ST_SPLIT_LO;
			end
			ST_UP_WR: begin
				state_d = ST_UP_RD;
			end
			ST_SPLIT_LO: begin
				state_d = ST_SPLIT_HI;
			end
			ST_SPLIT_HI: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (rsp_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		req.ready = (state_q == ST_IDLE);
		mem_req   = '0;
		case (state_q)
			ST_RESET: begin
				mem_req.we    = 1'b1;
				mem_req.wdata = '{base: '0, length: build_len};
			end
			ST_IDLE: begin
				mem_req.we    = req.valid && (req.cmd == CMD_INIT);
				mem_req.wdata = '{base: '0, length: build_len};
			end
			ST_SCAN_RD: begin
				mem_req.raddr = idx_q[IDX_W-1:0];
			end
			ST_SCAN_CMP: begin
				mem_req.waddr = idx_q[IDX_W-1:0];
				if (hit && !size_zero && at_front && !at_tail) begin
					mem_req.we    = 1'b1;
					mem_req.wdata = '{base: ADDR_W'(stop_q), length: LEN_W'(rd_end - stop_q)};
				end else if (hit && !size_zero && !at_front && at_tail) begin
					mem_req.we    = 1'b1;
					mem_req.wdata = '{base: mem_rdata.base,
						length: LEN_W'({1'b0, start_q}) - LEN_W'({1'b0, mem_rdata.base})};
				end
			end
			ST_DN_RD: begin
				mem_req.raddr = k_next[IDX_W-1:0];
			end
			ST_DN_WR: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = k_q[IDX_W-1:0];
				mem_req.wdata = mem_rdata;
			end
			ST_UP_RD: begin
				mem_req.raddr = k_prev[IDX_W-1:0];
			end
			ST_UP_WR: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = k_q[IDX_W-1:0];
				mem_req.wdata = mem_rdata;
			end
			ST_SPLIT_LO: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = idx_q[IDX_W-1:0];
				mem_req.wdata = '{base: base_q,
					length: LEN_W'({1'b0, start_q}) - LEN_W'({1'b0, base_q})};
			end
			ST_SPLIT_HI: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = idx_next[IDX_W-1:0];
				mem_req.wdata = '{base: ADDR_W'(stop_q), length: LEN_W'(end_q - stop_q)};
			end
			default: begin
				mem_req = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_RESET;
			total_size_q <= LEN_W'(MEM_WORDS);
			count_q      <= '0;
			idx_q        <= '0;
			k_q          <= '0;
			status_q     <= STATUS_OK;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				total_size_q <= cfg_wdata;
			end
			case (state_q)
				ST_RESET: begin
					count_q <= build_cnt;
				end
				ST_IDLE: begin
					if (accept) begin
						idx_q    <= '0;
						status_q <= STATUS_OK;
						if (req.cmd == CMD_INIT) begin
							count_q <= build_cnt;
						end
					end
				end
				ST_SCAN_RD: begin
					if (idx_q >= count_q) begin
						status_q <= STATUS_MISS;
					end
				end
				ST_SCAN_CMP: begin
					if (!hit) begin
						idx_q <= idx_next;
					end else if (!size_zero) begin
						if (at_front && at_tail) begin
							k_q <= idx_q;
						end else if (!at_front && !at_tail) begin
							if (full) begin
								status_q <= STATUS_FULL;
							end else begin
								k_q <= count_q;
							end
						end
					end
				end
				ST_DN_RD: begin
					if (!dn_more) begin
						count_q <= count_q - CNT_W'(1);
					end
				end
				ST_DN_WR: begin
					k_q <= k_next;
				end
				ST_UP_WR: begin
					k_q <= k_prev;
				end
				ST_SPLIT_HI: begin
					count_q <= count_q + CNT_W'(1);
				end
				default: begin
				end
			endcase
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			start_q <= req.seg_start;
			size_q  <= req.seg_size;
			stop_q  <= SPAN_W'(req.seg_start) + SPAN_W'(req.seg_size);
		end
		if (state_q == ST_SCAN_CMP) begin
			base_q <= mem_rdata.base;
			end_q  <= rd_end;
		end
		if (rsp_load) begin
			rsp_status_q <= status_q;
			rsp_count_q  <= count_q;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = rsp_status_q;
	assign rsp.free_count = rsp_count_q;

endmodule

>>> design/fasc_checker.sv
// Port-level checker of the fixed address segment carver and its bind statement.
module fasc_checker import fasc_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             rsp_valid,
	input logic             rsp_ready,
	input logic [1:0]       rsp_status,
	input logic [CNT_W-1:0] rsp_free_count
);

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_status == STATUS_OK) || (rsp_status == STATUS_MISS) ||
			(rsp_status == STATUS_FULL))
		else $error("Response word carries an undefined status.");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_free_count <= CNT_W'(MAX_RANGES))
		else $error("Free range count exceeds the table depth.");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == STATUS_FULL) |-> rsp_free_count == CNT_W'(MAX_RANGES))
		else $error("Table full reported while the table has room.");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
			$stable(rsp_free_count))
		else $error("Stalled response word changed or dropped.");

endmodule

bind fixed_address_segment_carver fasc_checker u_fasc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_status     (rsp.status),
	.rsp_free_count (rsp.free_count)
);

>>> test/fixed_address_segment_carver_tb.sv
// Testbench checking the carver word by word against its free-table predictor or set values.
`timescale 1ns / 1ps

module fixed_address_segment_carver_tb;
	import fasc_pkg::*;

	localparam int CYCLE_LIMIT     = 1000000;
	localparam int ITEMS_PER_PHASE = 64;
	localparam int NUM_PHASES      = 8;
	localparam int NUM_PROBES      = 22;
	localparam int HOLD_CYCLES     = 300;
	localparam int SETTLE_CYCLES   = 80;

	typedef struct packed {
		status_t          status;
		logic [CNT_W-1:0] count;
	} carve_result_t;

	typedef struct packed {
		bit                cfg_wr;
		logic [LEN_W-1:0]  cfg_val;
		cmd_t              cmd;
		logic [ADDR_W-1:0] start;
		logic [LEN_W-1:0]  size;
		int                reps;
		int                step;
		bit                typed;
		status_t           want_status;
		int                want_count;
	} probe_row_t;

	localparam probe_row_t PROBES [NUM_PROBES] = '{
		'{1'b0, 13'd0,    CMD_ALLOC, 12'd0,    13'd0,    1,  0, 1'b1, STATUS_OK,   1},
		'{1'b0, 13'd0,    CMD_ALLOC, 12'd4095, 13'd1,    1,  0, 1'b1, STATUS_OK,   1},
		'{1'b0, 13'd0,    CMD_ALLOC, 12'd0,    13'd1,    1,  0, 1'b1, STATUS_OK,   1},
		'{1'b0, 13'd0,    CMD_ALLOC, 12'd100,  13'd10,   1,  0, 1'b1, STATUS_OK,   2},
		'{1'b0, 13'd0,    CMD_ALLOC, 12'd100,  13'd10,   1,  0, 1'b1, STATUS_MISS, 2},
		'{1'b0, 13'd0,    CMD_ALLOC, 12'd110,  13'd3985, 1,  0, 1'b1, STATUS_OK,   1},
		'{1'b0, 13'd0,    CMD_ALLOC, 12'd4095, 13'd0,    1,  0, 1'b1, STATUS_MISS, 1},
		'{1'b0, 13'd0,    CMD_ALLOC, 12'd100,  13'd0,    1,  0, 1'b1, STATUS_OK,   1},
		'{1'b0, 13'd0,    CMD_INIT,  12'd4095, 13'd4096, 1,  0, 1'b1, STATUS_OK,   1},
		'{1'b0, 13'd0,    CMD_ALLOC, 12'd4095, 13'd4096, 1,  0, 1'b1, STATUS_MISS, 1},
		'{1'b0, 13'd0,    CMD_ALLOC, 12'd0,    13'd4096, 1,  0, 1'b1, STATUS_OK,   0},
		'{1'b0, 13'd0,    CMD_ALLOC, 12'd0,    13'd0,    1,  0, 1'b1, STATUS_MISS, 0},
		'{1'b1, 13'd8191, CMD_INIT,  12'd0,    13'd0,    1,  0, 1'b1, STATUS_OK,   1},
		'{1'b0, 13'd0,    CMD_ALLOC, 12'd0,    13'd4096, 1,  0, 1'b1, STATUS_OK,   0},
		'{1'b1, 13'd0,    CMD_INIT,  12'd0,    13'd0,    1,  0, 1'b1, STATUS_OK,   0},
		'{1'b0, 13'd0,    CMD_ALLOC, 12'd0,    13'd0,    1,  0, 1'b1, STATUS_MISS, 0},
		'{1'b1, 13'd4096, CMD_INIT,  12'd0,    13'd0,    1,  0, 1'b1, STATUS_OK,   1},
		'{1'b0, 13'd0,    CMD_ALLOC, 12'd1,    13'd1,    15, 2, 1'b0, STATUS_OK,   0},
		'{1'b0, 13'd0,    CMD_ALLOC, 12'd31,   13'd1,    1,  0, 1'b1, STATUS_FULL, 16},
		'{1'b0, 13'd0,    CMD_ALLOC, 12'd2,    13'd1,    1,  0, 1'b1, STATUS_OK,   15},
		'{1'b0, 13'd0,    CMD_ALLOC, 12'd4095, 13'd1,    1,  0, 1'b1, STATUS_OK,   15},
		'{1'b0, 13'd0,    CMD_INIT,  12'd0,    13'd0,    1,  0, 1'b1, STATUS_OK,   1}
	};

	localparam int PHASE_IDLE [NUM_PHASES] = '{0, 1, 2, 3, 0, 1, 2, 3};
	localparam int PHASE_MEM [NUM_PHASES]  = '{4096, 1, 8191, 37, 0, 4096, 300, 4096};

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [LEN_W-1:0] cfg_wdata;

	fasc_req_if req_if ();
	fasc_rsp_if rsp_if ();

	fixed_address_segment_carver u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_if),
		.rsp       (rsp_if),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	logic [ADDR_W-1:0] free_base [MAX_RANGES];
	logic [LEN_W-1:0]  free_len [MAX_RANGES];
	int                free_cnt;
	logic [LEN_W-1:0]  mem_size_cfg;

	carve_result_t pending_results [$];
	int            error_count = 0;
	int            cycle_count = 0;
	int            send_idle_pct = 0;
	int            recv_stall_pct = 0;
	bit            hold_go = 1'b0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("fixed_address_segment_carver_tb NOT OK");
			$finish;
		end
	end

	function automatic void rebuild_free_table();
		int sz;
		sz = mem_size_cfg;
		if (sz > MEM_WORDS)
			sz = MEM_WORDS;
		for (int i = 0; i < MAX_RANGES; i++) begin
			free_base[i] = '0;
			free_len[i]  = '0;
		end
		free_len[0] = LEN_W'(sz);
		free_cnt = (sz == 0) ? 0 : 1;
	endfunction

	function automatic status_t carve_segment(int s, int z);
		int hit, i, b, e, stop;
		hit = -1;
		stop = s + z;
		i = 0;
		while (hit < 0 && i < free_cnt) begin
			if (int'(free_base[i]) <= s && int'(free_base[i]) + int'(free_len[i]) >= stop)
				hit = i;
			i++;
		end
		if (hit < 0)
			return STATUS_MISS;
		if (z == 0)
			return STATUS_OK;
		b = free_base[hit];
		e = b + int'(free_len[hit]);
		if (b == s) begin
			if (e == stop) begin
				for (i = hit; i + 1 < free_cnt; i++) begin
					free_base[i] = free_base[i + 1];
					free_len[i]  = free_len[i + 1];
				end
				free_cnt--;
			end else begin
				free_base[hit] = ADDR_W'(stop);
				free_len[hit]  = LEN_W'(e - stop);
			end
			return STATUS_OK;
		end
		if (e == stop) begin
			free_len[hit] = LEN_W'(s - b);
			return STATUS_OK;
		end
		if (free_cnt >= MAX_RANGES)
			return STATUS_FULL;
		for (i = free_cnt; i > hit + 1; i--) begin
			free_base[i] = free_base[i - 1];
			free_len[i]  = free_len[i - 1];
		end
		free_len[hit]      = LEN_W'(s - b);
		free_base[hit + 1] = ADDR_W'(stop);
		free_len[hit + 1]  = LEN_W'(e - stop);
		free_cnt++;
		return STATUS_OK;
	endfunction

	function automatic carve_result_t apply_word(cmd_t c, int s, int z);
		carve_result_t r;
		r.status = STATUS_OK;
		if (c == CMD_INIT)
			rebuild_free_table();
		else
			r.status = carve_segment(s, z);
		r.count = CNT_W'(free_cnt);
		return r;
	endfunction

	function automatic void pick_request(output logic [ADDR_W-1:0] s, output logic [LEN_W-1:0] z);
		int i, b, l, off, kind, ss, zz;
		if (free_cnt == 0 || $urandom_range(99) < 12) begin
			ss = $urandom_range(0, MEM_WORDS - 1);
			zz = ($urandom_range(3) == 0) ? $urandom_range(0, MEM_WORDS) : $urandom_range(0, 64);
		end else begin
			i = $urandom_range(0, free_cnt - 1);
			b = free_base[i];
			l = free_len[i];
			kind = $urandom_range(0, 7);
			ss = b;
			zz = l;
			case (kind)
				0: if (l > 1) zz = $urandom_range(1, l - 1);
				1: if (l > 1) begin
					off = $urandom_range(1, l - 1);
					ss = b + off;
					zz = l - off;
				end
				2: ;
				3, 4, 5: if (l > 2) begin
					off = $urandom_range(1, l - 2);
					ss = b + off;
					zz = $urandom_range(1, (l - 1 - off > 16) ? 16 : l - 1 - off);
				end
				6: begin
					ss = (b + l > MEM_WORDS - 1) ? b + $urandom_range(0, l - 1) : b + $urandom_range(0, l);
					zz = 0;
				end
				default: if (l < MEM_WORDS) zz = l + 1;
			endcase
		end
		s = ADDR_W'(ss);
		z = LEN_W'(zz);
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		if (error_count < 50)
			$display("mismatch at cycle %0d: %s got %0d, expected %0d", cycle_count, what, got, want);
		error_count++;
	endtask

	task automatic send_word(input cmd_t c, input logic [ADDR_W-1:0] s, input logic [LEN_W-1:0] z,
			input bit typed, input status_t want_st, input int want_cnt);
		carve_result_t outcome;
		while ($urandom_range(99) < send_idle_pct) begin
			req_if.valid     = 1'b0;
			req_if.cmd       = 1'($urandom);
			req_if.seg_start = ADDR_W'($urandom);
			req_if.seg_size  = LEN_W'($urandom);
			@(negedge clk);
		end
		req_if.valid     = 1'b1;
		req_if.cmd       = c;
		req_if.seg_start = s;
		req_if.seg_size  = z;
		do
			@(posedge clk);
		while (req_if.ready !== 1'b1);
		outcome = apply_word(c, s, z);
		if (typed) begin
			outcome.status = want_st;
			outcome.count  = CNT_W'(want_cnt);
		end
		pending_results.push_back(outcome);
		@(negedge clk);
	endtask

	task automatic wait_until_drained();
		req_if.valid = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_mem_size(input logic [LEN_W-1:0] v);
		wait_until_drained();
		repeat (4) @(negedge clk);
		cfg_we       = 1'b1;
		cfg_wdata    = v;
		mem_size_cfg = v;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	initial begin
		int hold_left;
		rsp_if.ready = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_go) begin
				hold_go = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				rsp_if.ready = 1'b0;
				hold_left--;
			end else begin
				rsp_if.ready = ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		carve_result_t want;
		if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				report_mismatch("word with nothing pending, status", rsp_if.status, -1);
			end else begin
				want = pending_results.pop_front();
				if (rsp_if.status !== want.status)
					report_mismatch("status", rsp_if.status, want.status);
				if (rsp_if.free_count !== want.count)
					report_mismatch("free_count", rsp_if.free_count, want.count);
			end
		end
	end

	initial begin
		int r, n, p, k;
		logic [ADDR_W-1:0] s;
		logic [LEN_W-1:0]  z;
		req_if.valid     = 1'b0;
		req_if.cmd       = CMD_INIT;
		req_if.seg_start = '0;
		req_if.seg_size  = '0;
		cfg_we           = 1'b0;
		cfg_wdata        = '0;
		arst_n           = 1'b0;
		mem_size_cfg     = LEN_W'(MEM_WORDS);
		rebuild_free_table();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (r = 0; r < NUM_PROBES; r++) begin
			if (PROBES[r].cfg_wr)
				write_mem_size(PROBES[r].cfg_val);
			for (n = 0; n < PROBES[r].reps; n++)
				send_word(PROBES[r].cmd, ADDR_W'(PROBES[r].start + n * PROBES[r].step),
					PROBES[r].size, PROBES[r].typed, PROBES[r].want_status,
					PROBES[r].want_count);
		end

		for (p = 0; p < NUM_PHASES; p++) begin
			write_mem_size(LEN_W'(PHASE_MEM[p]));
			case (PHASE_IDLE[p])
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 73;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 73;
				end
				default: begin
					send_idle_pct  = 36;
					recv_stall_pct = 36;
				end
			endcase
			send_word(CMD_INIT, ADDR_W'($urandom), LEN_W'($urandom), 1'b0, STATUS_OK, 0);
			if (p == 0)
				hold_go = 1'b1;
			for (k = 0; k < ITEMS_PER_PHASE; k++) begin
				if (k == ITEMS_PER_PHASE / 2)
					wait_until_drained();
				if ($urandom_range(24) == 0) begin
					send_word(CMD_INIT, ADDR_W'($urandom), LEN_W'($urandom), 1'b0, STATUS_OK, 0);
				end else begin
					pick_request(s, z);
					send_word(CMD_ALLOC, s, z, 1'b0, STATUS_OK, 0);
				end
			end
		end

		wait_until_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (error_count == 0)
			$display("fixed_address_segment_carver_tb OK");
		else
			$display("fixed_address_segment_carver_tb NOT OK");
		$finish;
	end

endmodule

>>> fixed_address_segment_carver.f
design/fasc_pkg.sv
design/fasc_if.sv
design/fasc_table_ram.sv
design/fasc_ctrl.sv
design/fixed_address_segment_carver.sv
design/fasc_checker.sv
test/fixed_address_segment_carver_tb.sv
